// ===== rtl/opdt_pkg.sv =====
// ----------------------------------------------------------------------------
// opdt_pkg
// Shared field widths, result codes and configuration register indexes for
// the object position deduplication table.
// ----------------------------------------------------------------------------
package opdt_pkg;

  localparam int CLASS_W  = 5;
  localparam int POS_W    = 24;
  localparam int THR_W    = 23;
  localparam int STATUS_W = 3;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 7;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int ENTRY_W = CLASS_W + 3 * POS_W;
  localparam int SQ_W    = 2 * POS_W;
  localparam int ACC_W   = SQ_W + 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_TOO_FAR   = 3'd0,
    ST_UNTRACKED = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_ADDED     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DEPTH   = 3'd0,
    REG_CLASS_A     = 3'd1,
    REG_CLASS_B     = 3'd2,
    REG_THRESHOLD_A = 3'd3,
    REG_THRESHOLD_B = 3'd4
  } cfg_reg_t;

endpackage

// ===== rtl/opdt_ram.sv =====
// ----------------------------------------------------------------------------
// opdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module opdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/object_position_dedup_table_core.sv =====
// ----------------------------------------------------------------------------
// object_position_dedup_table_core
// Landmark deduplication: drops detections that are too deep, untracked, or
// within a per-class distance of a stored entry; appends the rest unless full.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one detection per transfer; m_* returns exactly one result
//   per detection. cfg_* writes a register (index, data); it is always ready
//   and is meant to be written while no detection is in flight.
//   The block holds one detection at a time: s_tready is low from the accept
//   until the result has been taken on m_*.
//   Sequence: a detection that is too deep or of an untracked class yields
//   its result in the cycle after the accept. A tracked detection first squares
//   its threshold, then reads the stored entries in order; each entry of the
//   same class has its three axis differences squared, summed and compared
//   with that limit. The search stops at the first match. The single 24x24
//   multiplier, shared by the threshold square and the three axis squares,
//   and the one-read-port entry RAM set the pace of this search.
//   Reset empties the table and restores the register defaults. A stalled
//   receiver holds the result on m_tdata and blocks new detections.
// ----------------------------------------------------------------------------
module object_position_dedup_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // class_id[4:0], camera_depth[28:5], world_x[52:29], world_y[76:53],
  // world_z[100:77], zero fill
  input  logic [opdt_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[2:0], entry_index[8:3], entry_count[15:9]
  output logic [opdt_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [opdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [opdt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import opdt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LIMIT = 10'b0000000010,
    S_LSAVE = 10'b0000000100,
    S_READ  = 10'b0000001000,
    S_MX    = 10'b0000010000,
    S_MY    = 10'b0000100000,
    S_MZ    = 10'b0001000000,
    S_ACC   = 10'b0010000000,
    S_CMP   = 10'b0100000000,
    S_END   = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    OP_THR = 2'd0,
    OP_X   = 2'd1,
    OP_Y   = 2'd2,
    OP_Z   = 2'd3
  } mul_sel_t;

  state_t state;
  state_t state_next;
  logic   out_valid;

  logic [THR_W-1:0]   max_depth;
  logic [CLASS_W-1:0] class_a;
  logic [CLASS_W-1:0] class_b;
  logic [THR_W-1:0]   threshold_a;
  logic [THR_W-1:0]   threshold_b;

  logic [CLASS_W-1:0] det_class;
  logic [POS_W-1:0]   det_x;
  logic [POS_W-1:0]   det_y;
  logic [POS_W-1:0]   det_z;
  logic [THR_W-1:0]   det_thr;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [SQ_W-1:0]  limit;
  logic [SQ_W-1:0]  prod;
  logic [ACC_W-1:0] acc;

  status_t          res_status;
  logic [IDX_W-1:0] res_index;

  logic [CLASS_W-1:0] in_class;
  logic [POS_W-1:0]   in_depth;
  logic               in_too_far;
  logic               in_tracked;
  logic               s_fire;
  logic               m_fire;

  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [CLASS_W-1:0] ent_class;
  logic [POS_W-1:0]   ent_x;
  logic [POS_W-1:0]   ent_y;
  logic [POS_W-1:0]   ent_z;

  mul_sel_t         mul_sel;
  logic [POS_W-1:0] op_a;
  logic [POS_W-1:0] op_b;
  logic [POS_W:0]   diff;
  logic [POS_W-1:0] mag;
  logic [POS_W-1:0] mul_in;

  logic last_entry;
  logic table_full;

  logic [IDX_W+OUT_IDX_W-1:0] index_wide;
  logic [CNT_W+OUT_CNT_W-1:0] count_wide;

  assign s_tready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign s_fire    = s_tvalid && s_tready;
  assign m_fire    = out_valid && m_tready;

  assign in_class   = s_tdata[CLASS_W-1:0];
  assign in_depth   = s_tdata[CLASS_W +: POS_W];
  assign in_too_far = !in_depth[POS_W-1] && (in_depth[THR_W-1:0] > max_depth);
  assign in_tracked = (in_class == class_a) || (in_class == class_b);

  assign {ent_z, ent_y, ent_x, ent_class} = ram_rdata;
  assign ram_wdata  = {det_z, det_y, det_x, det_class};
  assign ram_waddr  = count[IDX_W-1:0];
  assign table_full = (count == CNT_W'(TABLE_DEPTH));
  assign ram_we     = (state == S_END) && !table_full;
  assign last_entry = ((CNT_W'(idx) + CNT_W'(1)) == count);

  opdt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // Shared magnitude and square unit
  always_comb begin
    mul_sel = OP_THR;
    unique case (state)
      S_MX:    mul_sel = OP_X;
      S_MY:    mul_sel = OP_Y;
      S_MZ:    mul_sel = OP_Z;
      default: mul_sel = OP_THR;
    endcase
    op_a = '0;
    op_b = '0;
    case (mul_sel)
      OP_X: begin
        op_a = ent_x;
        op_b = det_x;
      end
      OP_Y: begin
        op_a = ent_y;
        op_b = det_y;
      end
      OP_Z: begin
        op_a = ent_z;
        op_b = det_z;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    diff = {op_a[POS_W-1], op_a} - {op_b[POS_W-1], op_b};
    mag  = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
    mul_in = (mul_sel == OP_THR) ? {1'b0, det_thr} : mag;
  end

  always_ff @(posedge clk) begin
    prod <= SQ_W'(mul_in) * SQ_W'(mul_in);
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        if (s_fire && !in_too_far && in_tracked) begin
          state_next = S_LIMIT;
        end
      end
      S_LIMIT: state_next = S_LSAVE;
      S_LSAVE: begin
        idx_next   = '0;
        state_next = (count == '0) ? S_END : S_READ;
      end
      S_READ: state_next = S_MX;
      S_MX: begin
        if (ent_class == det_class) begin
          state_next = S_MY;
        end else if (last_entry) begin
          state_next = S_END;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_READ;
        end
      end
      S_MY:  state_next = S_MZ;
      S_MZ:  state_next = S_ACC;
      S_ACC: state_next = S_CMP;
      S_CMP: begin
        if (acc < ACC_W'(limit)) begin
          state_next = S_IDLE;
        end else if (last_entry) begin
          state_next = S_END;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_READ;
        end
      end
      S_END:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      count       <= '0;
      max_depth   <= THR_W'(196608);
      class_a     <= CLASS_W'(5);
      class_b     <= CLASS_W'(20);
      threshold_a <= THR_W'(13107);
      threshold_b <= THR_W'(65536);
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_DEPTH:   max_depth   <= cfg_data[THR_W-1:0];
          REG_CLASS_A:     class_a     <= cfg_data[CLASS_W-1:0];
          REG_CLASS_B:     class_b     <= cfg_data[CLASS_W-1:0];
          REG_THRESHOLD_A: threshold_a <= cfg_data[THR_W-1:0];
          REG_THRESHOLD_B: threshold_b <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (m_fire) begin
        out_valid <= 1'b0;
      end
      if (s_fire && (in_too_far || !in_tracked)) begin
        out_valid <= 1'b1;
      end
      if (state == S_CMP && acc < ACC_W'(limit)) begin
        out_valid <= 1'b1;
      end
      if (state == S_END) begin
        out_valid <= 1'b1;
        if (!table_full) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    if (s_fire) begin
      det_class  <= in_class;
      det_x      <= s_tdata[CLASS_W + POS_W     +: POS_W];
      det_y      <= s_tdata[CLASS_W + 2 * POS_W +: POS_W];
      det_z      <= s_tdata[CLASS_W + 3 * POS_W +: POS_W];
      det_thr    <= (in_class == class_a) ? threshold_a : threshold_b;
      res_index  <= '0;
      res_status <= in_too_far ? ST_TOO_FAR : ST_UNTRACKED;
    end
    if (state == S_LSAVE) begin
      limit <= prod;
    end
    if (state == S_MY) begin
      acc <= ACC_W'(prod);
    end
    if (state == S_MZ || state == S_ACC) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == S_CMP && acc < ACC_W'(limit)) begin
      res_status <= ST_DUPLICATE;
      res_index  <= idx;
    end
    if (state == S_END) begin
      res_status <= table_full ? ST_FULL : ST_ADDED;
      res_index  <= table_full ? '0 : count[IDX_W-1:0];
    end
  end

  assign index_wide = {{OUT_IDX_W{1'b0}}, res_index};
  assign count_wide = {{OUT_CNT_W{1'b0}}, count};
  assign m_tdata    = {count_wide[OUT_CNT_W-1:0], index_wide[OUT_IDX_W-1:0], res_status};

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_END) && !table_full |=> count == $past(count) + CNT_W'(1))
    else $error("append did not advance entry count");

  a_dup_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_status == ST_DUPLICATE) |-> CNT_W'(res_index) < count)
    else $error("duplicate index outside stored entries");

endmodule
